// File: hw/rtl/utf8vd_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
package utf8vd_pkg;

   // Code point counter width; the counter saturates at all ones.
   localparam int COUNT_WIDTH = 20;
   // Capacity register width; CMP_WIDTH is wide enough for both the counter and the capacity.
   localparam int CAP_WIDTH   = 20;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;

   // Result queue: depth and index widths.
   localparam int RQ_DEPTH    = 8;
   localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W    = $clog2(RQ_DEPTH + 1);

   // CSR register indexes.
   localparam logic CSR_DECODE_MODE     = 1'b0;
   localparam logic CSR_OUTPUT_CAPACITY = 1'b1;

   // Decode modes.
   localparam logic MODE_STANDARD = 1'b0;
   localparam logic MODE_MODIFIED = 1'b1;

   // Value limits.
   localparam logic [20:0] MAX_CP      = 21'h10FFFF;
   localparam logic [20:0] SURR_LO     = 21'h00D800;
   localparam logic [20:0] SURR_LOW_LO = 21'h00DC00;
   localparam logic [20:0] SURR_HI     = 21'h00DFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;
   localparam logic [20:0] MIN_TWO     = 21'h000080;
   localparam logic [20:0] MIN_THREE   = 21'h000800;

   typedef struct packed {
      logic [20:0] code_point;
      logic        is_summary;
      logic        well_formed;
      logic        truncated;
      logic [19:0] point_count;
      logic        last_result;
   } result_type;

endpackage

// File: hw/rtl/utf8_validating_decoder_core.sv
// UTF-8 / modified UTF-8 validating decoder, one byte per word.
//
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tdata[7:0] byte_in, tlast last_byte
// rsp      out  rsp_tvalid/tready     tdata code_point..point_count, tuser is_summary,
//                                     tlast last_result
// csr      in   csr_valid/csr_ready   csr_index register, csr_data value
//
// One byte is taken per clock while req_tready is high. A byte is captured in
// the input register and decoded in the next cycle; its results land in an
// 8-entry result queue that feeds the rsp channel.
// A final byte may produce two results (a code point and the summary); the
// queue keeps room for two results per byte in flight, which sets req_tready.
// Reset (synchronous, active high) restores the default CSRs and an empty text.
// A stalled rsp side only stalls req once the queue runs short of room.
module utf8_validating_decoder_core (
   input  logic        clock,
   input  logic        reset,
   // byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // last_byte
   // decoded stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [20:0] code_point, [21] well_formed,
                                    // [22] truncated, [42:23] point_count, rest zero
   output logic        rsp_tuser,   // is_summary
   output logic        rsp_tlast,   // last_result
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [19:0] csr_data
);

   localparam int CW = utf8vd_pkg::COUNT_WIDTH;
   localparam int MW = utf8vd_pkg::CMP_WIDTH;
   localparam int DEPTH = utf8vd_pkg::RQ_DEPTH;
   localparam int PW = utf8vd_pkg::RQ_PTR_W;
   localparam int NW = utf8vd_pkg::RQ_CNT_W;

   // ---------------- configuration ----------------
   logic        decode_mode_ff;
   logic [19:0] output_capacity_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff     <= utf8vd_pkg::MODE_STANDARD;
         output_capacity_ff <= 20'hFFFFF;
      end else if (csr_valid) begin
         case (csr_index)
            utf8vd_pkg::CSR_DECODE_MODE:     decode_mode_ff     <= csr_data[0];
            utf8vd_pkg::CSR_OUTPUT_CAPACITY: output_capacity_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic       stage_valid_ff;
   logic [7:0] stage_byte_ff;
   logic       stage_last_ff;
   logic       req_fire;

   // Result queue bookkeeping (declared early, used by ready)
   logic [NW-1:0] rq_count_ff, rq_count_in;
   logic [PW-1:0] rq_wr_ff, rq_rd_ff;
   logic [NW:0]   rq_claim;

   // Room for two results of the byte in the input register and two more.
   assign rq_claim   = (NW+1)'(rq_count_ff) + (stage_valid_ff ? (NW+1)'(2) : (NW+1)'(0));
   assign req_tready = rq_claim <= (NW+1)'(DEPTH - 2);
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_byte_ff <= req_tdata;
         stage_last_ff <= req_tlast;
      end
   end

   // ---------------- decode state ----------------
   logic [1:0]  bytes_pending_ff, bytes_pending_in;
   logic [2:0]  seq_length_ff, seq_length_in;
   logic [20:0] accumulator_ff, accumulator_in;
   logic [9:0]  high_unit_ff, high_unit_in;
   logic        high_valid_ff, high_valid_in;
   logic        error_seen_ff, error_seen_in;
   logic [CW-1:0] emitted_count_ff, emitted_count_in;
   logic        overflowed_ff, overflowed_in;

   utf8vd_pkg::result_type res0, res1;
   logic [1:0] push_n;

   // Single pass over one byte: sequence tracking, unit checks, emit, summary.
   always_comb begin
      logic        unit_done;
      logic [20:0] v;
      logic [20:0] minimum;
      logic        mnull;
      logic        want_emit;
      logic [20:0] emit_cp;
      logic        cp_out;
      logic [MW-1:0] cnt_ext;
      logic [MW-1:0] cap_ext;
      logic [MW-1:0] cnt_after;
      logic [7:0]  b;
      logic        mode;

      b       = stage_byte_ff;
      mode    = decode_mode_ff;

      bytes_pending_in = bytes_pending_ff;
      seq_length_in    = seq_length_ff;
      accumulator_in   = accumulator_ff;
      high_unit_in     = high_unit_ff;
      high_valid_in    = high_valid_ff;
      error_seen_in    = error_seen_ff;
      emitted_count_in = emitted_count_ff;
      overflowed_in    = overflowed_ff;

      unit_done = 1'b0;
      want_emit = 1'b0;
      emit_cp   = '0;
      cp_out    = 1'b0;
      minimum   = '0;
      mnull     = 1'b0;
      v         = '0;
      cnt_ext   = MW'(emitted_count_ff);
      cap_ext   = MW'(output_capacity_ff);
      cnt_after = '0;
      res0      = '0;
      res1      = '0;
      push_n    = 2'd0;

      if (stage_valid_ff && !error_seen_ff) begin
         // sequence tracking
         if (bytes_pending_ff == 2'd0) begin
            if (b[7] == 1'b0) begin
               accumulator_in = {13'd0, b};
               seq_length_in  = 3'd1;
               unit_done      = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               accumulator_in   = {16'd0, b[4:0]};
               seq_length_in    = 3'd2;
               bytes_pending_in = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               accumulator_in   = {17'd0, b[3:0]};
               seq_length_in    = 3'd3;
               bytes_pending_in = 2'd2;
            end else if (mode == utf8vd_pkg::MODE_STANDARD && b[7:3] == 5'b11110) begin
               accumulator_in   = {18'd0, b[2:0]};
               seq_length_in    = 3'd4;
               bytes_pending_in = 2'd3;
            end else begin
               error_seen_in = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            error_seen_in = 1'b1;
         end else begin
            accumulator_in   = {accumulator_ff[14:0], b[5:0]};
            bytes_pending_in = bytes_pending_ff - 2'd1;
            unit_done        = (bytes_pending_ff == 2'd1);
         end

         // unit checks
         if (unit_done) begin
            v = accumulator_in;
            case (seq_length_in)
               3'd2:    minimum = utf8vd_pkg::MIN_TWO;
               3'd3:    minimum = utf8vd_pkg::MIN_THREE;
               3'd4:    minimum = utf8vd_pkg::SUPP_BASE;
               default: minimum = '0;
            endcase
            // modified mode: C0 80 stands for zero
            mnull = (mode == utf8vd_pkg::MODE_MODIFIED) && (seq_length_in == 3'd2)
                    && (v == '0);
            if ((!mnull && v < minimum) || v > utf8vd_pkg::MAX_CP ||
                (mode == utf8vd_pkg::MODE_STANDARD && v >= utf8vd_pkg::SURR_LO &&
                 v <= utf8vd_pkg::SURR_HI)) begin
               error_seen_in = 1'b1;
            end else if (high_valid_ff) begin
               // pending high surrogate must pair with a low one
               if (v < utf8vd_pkg::SURR_LOW_LO || v > utf8vd_pkg::SURR_HI) begin
                  error_seen_in = 1'b1;
               end else begin
                  high_valid_in = 1'b0;
                  want_emit     = 1'b1;
                  emit_cp       = utf8vd_pkg::SUPP_BASE + {1'b0, high_unit_ff, v[9:0]};
               end
            end else if (v >= utf8vd_pkg::SURR_LO && v < utf8vd_pkg::SURR_LOW_LO) begin
               high_unit_in  = v[9:0];
               high_valid_in = 1'b1;
            end else if (v >= utf8vd_pkg::SURR_LOW_LO && v <= utf8vd_pkg::SURR_HI) begin
               error_seen_in = 1'b1;
            end else begin
               want_emit = 1'b1;
               emit_cp   = v;
            end
         end

         // emit against capacity and counter limit
         if (want_emit) begin
            if (cnt_ext < cap_ext && emitted_count_ff != {CW{1'b1}}) begin
               emitted_count_in = emitted_count_ff + CW'(1);
               cnt_after        = MW'(emitted_count_in);
               cp_out           = 1'b1;
               res0.code_point  = emit_cp;
               res0.is_summary  = 1'b0;
               res0.well_formed = 1'b1;
               res0.truncated   = overflowed_ff;
               res0.point_count = cnt_after[19:0];
               res0.last_result = 1'b0;
            end else begin
               overflowed_in = 1'b1;
            end
         end
      end

      if (stage_valid_ff && stage_last_ff) begin
         // text ends mid-sequence or with an unpaired high surrogate
         if (!error_seen_in && (bytes_pending_in != 2'd0 || high_valid_in)) begin
            error_seen_in = 1'b1;
         end
         cnt_after = MW'(emitted_count_in);
         if (cp_out) begin
            res1.code_point  = '0;
            res1.is_summary  = 1'b1;
            res1.well_formed = !error_seen_in;
            res1.truncated   = overflowed_in;
            res1.point_count = cnt_after[19:0];
            res1.last_result = 1'b1;
            push_n           = 2'd2;
         end else begin
            res0.code_point  = '0;
            res0.is_summary  = 1'b1;
            res0.well_formed = !error_seen_in;
            res0.truncated   = overflowed_in;
            res0.point_count = cnt_after[19:0];
            res0.last_result = 1'b1;
            push_n           = 2'd1;
         end
         // back to an empty text
         bytes_pending_in = '0;
         seq_length_in    = '0;
         accumulator_in   = '0;
         high_unit_in     = '0;
         high_valid_in    = 1'b0;
         error_seen_in    = 1'b0;
         emitted_count_in = '0;
         overflowed_in    = 1'b0;
      end else if (cp_out) begin
         push_n = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff <= '0;
         seq_length_ff    <= '0;
         accumulator_ff   <= '0;
         high_unit_ff     <= '0;
         high_valid_ff    <= 1'b0;
         error_seen_ff    <= 1'b0;
         emitted_count_ff <= '0;
         overflowed_ff    <= 1'b0;
      end else if (stage_valid_ff) begin
         bytes_pending_ff <= bytes_pending_in;
         seq_length_ff    <= seq_length_in;
         accumulator_ff   <= accumulator_in;
         high_unit_ff     <= high_unit_in;
         high_valid_ff    <= high_valid_in;
         error_seen_ff    <= error_seen_in;
         emitted_count_ff <= emitted_count_in;
         overflowed_ff    <= overflowed_in;
      end
   end

   // ---------------- result queue ----------------
   utf8vd_pkg::result_type rq_mem_ff [DEPTH];
   utf8vd_pkg::result_type rq_head;
   logic rq_pop;

   assign rq_head    = rq_mem_ff[rq_rd_ff];
   assign rsp_tvalid = (rq_count_ff != '0);
   assign rq_pop     = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {5'd0, rq_head.point_count, rq_head.truncated,
                        rq_head.well_formed, rq_head.code_point};
   assign rsp_tuser  = rq_head.is_summary;
   assign rsp_tlast  = rq_head.last_result;

   assign rq_count_in = rq_count_ff - (rq_pop ? NW'(1) : NW'(0)) + NW'(push_n);

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_count_ff <= '0;
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
      end else begin
         rq_count_ff <= rq_count_in;
         rq_wr_ff    <= rq_wr_ff + PW'(push_n);
         if (rq_pop) begin
            rq_rd_ff <= rq_rd_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         rq_mem_ff[rq_wr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         rq_mem_ff[rq_wr_ff + PW'(1)] <= res1;
      end
   end

   // ---------------- assertions ----------------
   a_rq_no_overfill: assert property (@(posedge clock) disable iff (reset)
      rq_count_ff <= NW'(DEPTH))
      else $error("result queue overfilled");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (rq_count_ff <= NW'(DEPTH - 2)))
      else $error("byte accepted without queue room");

   a_text_cleared: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && stage_last_ff |=>
         (bytes_pending_ff == 2'd0) && !error_seen_ff && !high_valid_ff &&
         (emitted_count_ff == '0) && !overflowed_ff)
      else $error("text state not cleared after final word");

   a_pending_len: assert property (@(posedge clock) disable iff (reset)
      (bytes_pending_ff != 2'd0) |-> (seq_length_ff >= 3'd2))
      else $error("continuation expected outside a multi-byte sequence");

endmodule
